// ===== design/nus_pkg.sv =====
package nus_pkg;

  localparam int OFF_W     = 24;
  localparam int LEN_W     = 25;
  localparam int TYPE_W    = 5;
  localparam int STAMP_W   = 64;

  localparam logic [TYPE_W-1:0] TYPE_MASK = 5'h1F;

  localparam logic [TYPE_W-1:0] NAL_SLICE = 5'd1;
  localparam logic [TYPE_W-1:0] NAL_IDR   = 5'd5;
  localparam logic [TYPE_W-1:0] NAL_SPS   = 5'd7;
  localparam logic [TYPE_W-1:0] NAL_PPS   = 5'd8;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    CLASS_OTHER = 2'd0,
    CLASS_PARAM = 2'd1,
    CLASS_INTRA = 2'd2,
    CLASS_PRED  = 2'd3
  } frame_class_t;

  typedef struct packed {
    logic [OFF_W-1:0]          offset;
    logic [LEN_W-1:0]          length;
    logic [TYPE_W-1:0]         ntype;
    frame_class_t              fclass;
    logic signed [STAMP_W-1:0] stamp;
    logic                      last;
  } desc_t;

  function automatic frame_class_t class_of(input logic [TYPE_W-1:0] t);
    frame_class_t c;
    c = CLASS_OTHER;
    if (t == NAL_SPS || t == NAL_PPS) begin
      c = CLASS_PARAM;
    end else if (t == NAL_IDR) begin
      c = CLASS_INTRA;
    end else if (t == NAL_SLICE) begin
      c = CLASS_PRED;
    end
    return c;
  endfunction

endpackage

// ===== design/nus_fifo.sv =====
module nus_fifo
  import nus_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  desc_t      din0,
  input  desc_t      din1,
  output logic       has_room,
  output logic       out_valid,
  input  logic       out_ready,
  output desc_t      dout
);

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wp_second;

  assign out_valid = (cnt_r != '0);
  assign dout      = mem_r[rp_r];
  assign has_room  = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign wp_second = wp_r + QPTR_W'(1);

  always_comb begin
    wp_nxt  = wp_r + QPTR_W'(push_cnt);
    rp_nxt  = pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push_cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wp_r] <= din0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wp_second] <= din1;
    end
  end

endmodule

// ===== design/h264_nal_unit_splitter.sv =====
// H.264 Annex B start code parser.
// The input channel carries one stream byte per beat, a flag on the final
// byte of each buffer and the buffer's timestamp, which is latched at the
// buffer's first byte. The result channel carries one NAL unit descriptor
// per beat: offset and length of the unit including its start code, the
// 5-bit unit type, a frame class and the timestamp.
// Each byte is decoded in the cycle it is accepted and its descriptors are
// written into a four-entry output queue, whose registered head is offered
// on the result channel. A byte may close one unit and, at the end of a
// buffer, also report a start code found on its last byte, giving two
// descriptors in one beat; last_of_run marks the final one. The block takes
// one byte per cycle while the queue has room for two descriptors; when the
// receiver stalls the queue fills and in_ready falls, and the rate is then
// set by the output side.
// A synchronous reset clears the start code search, the byte position,
// the open unit and the queue.
module h264_nal_unit_splitter
  import nus_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_buffer_end,
  input  logic signed [STAMP_W-1:0] in_buffer_stamp,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OFF_W-1:0]          out_unit_offset,
  output logic [LEN_W-1:0]          out_unit_length,
  output logic [TYPE_W-1:0]         out_unit_type,
  output logic [1:0]                out_frame_class,
  output logic signed [STAMP_W-1:0] out_unit_stamp,
  output logic                      out_last_of_run
);

  typedef logic [OFFSET_BITS-1:0] pos_t;
  typedef logic [OFFSET_BITS:0]   span_t;

  logic [1:0]                zero_run_r, zero_run_nxt;
  pos_t                      pos_r, pos_nxt;
  pos_t                      start_r, start_nxt;
  logic                      open_r, open_nxt;
  logic                      hdr_pend_r, hdr_pend_nxt;
  logic [TYPE_W-1:0]         type_r, type_nxt;
  logic                      has_hdr_r, has_hdr_nxt;
  logic signed [STAMP_W-1:0] stamp_r, stamp_nxt;

  logic                      accept;
  logic                      is_code;
  logic [TYPE_W-1:0]         type_mid;
  logic                      has_mid;
  logic [TYPE_W-1:0]         type_emit;
  pos_t                      cstart;
  pos_t                      pos_inc;
  pos_t                      e2_start;
  logic [TYPE_W-1:0]         e2_type;
  logic                      e1_vld, e2_vld;
  desc_t                     d1, d2, din0, dout;
  logic [1:0]                push_cnt;
  logic                      has_room;

  function automatic span_t span(input pos_t from, input pos_t to);
    pos_t d;
    d = to - from;
    return (d == '0) ? {1'b1, {OFFSET_BITS{1'b0}}} : {1'b0, d};
  endfunction

  function automatic desc_t make_desc(input pos_t s, input span_t len,
                                      input logic [TYPE_W-1:0] t,
                                      input logic signed [STAMP_W-1:0] st,
                                      input logic lst);
    desc_t      d;
    logic [31:0] ws;
    logic [32:0] wl;
    ws       = 32'(s);
    wl       = 33'(len);
    d.offset = ws[OFF_W-1:0];
    d.length = wl[LEN_W-1:0];
    d.ntype  = t;
    d.fclass = class_of(t);
    d.stamp  = st;
    d.last   = lst;
    return d;
  endfunction

  assign in_ready = has_room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    stamp_nxt = (pos_r == '0) ? in_buffer_stamp : stamp_r;
    type_mid  = hdr_pend_r ? (in_data_byte[TYPE_W-1:0] & TYPE_MASK) : type_r;
    has_mid   = hdr_pend_r | has_hdr_r;
    type_emit = has_mid ? type_mid : '0;
    is_code   = (in_data_byte == BYTE_ONE) && (zero_run_r >= 2'd2);
    cstart    = pos_r - pos_t'((zero_run_r == 2'd3) ? 3 : 2);
    pos_inc   = pos_r + pos_t'(1);
    e2_start  = is_code ? cstart : start_r;
    e2_type   = is_code ? '0 : type_emit;
    e1_vld    = is_code && open_r;
    e2_vld    = in_buffer_end && (is_code || open_r);

    d1 = make_desc(start_r, span(start_r, cstart), type_emit, stamp_nxt, !e2_vld);
    d2 = make_desc(e2_start, span(e2_start, pos_inc), e2_type, stamp_nxt, 1'b1);

    din0     = e1_vld ? d1 : d2;
    push_cnt = accept ? (2'(e1_vld) + 2'(e2_vld)) : 2'd0;

    zero_run_nxt = zero_run_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    open_nxt     = open_r;
    hdr_pend_nxt = hdr_pend_r;
    type_nxt     = type_r;
    has_hdr_nxt  = has_hdr_r;

    if (accept) begin
      type_nxt     = type_mid;
      has_hdr_nxt  = has_mid;
      hdr_pend_nxt = 1'b0;
      priority if (is_code) begin
        start_nxt    = cstart;
        open_nxt     = 1'b1;
        hdr_pend_nxt = 1'b1;
        has_hdr_nxt  = 1'b0;
        type_nxt     = '0;
        zero_run_nxt = 2'd0;
      end else if (in_data_byte == BYTE_ZERO) begin
        zero_run_nxt = (zero_run_r == 2'd3) ? 2'd3 : zero_run_r + 2'd1;
      end else begin
        zero_run_nxt = 2'd0;
      end
      if (in_buffer_end) begin
        open_nxt     = 1'b0;
        hdr_pend_nxt = 1'b0;
        has_hdr_nxt  = 1'b0;
        type_nxt     = '0;
        zero_run_nxt = 2'd0;
        pos_nxt      = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= '0;
      pos_r      <= '0;
      start_r    <= '0;
      open_r     <= 1'b0;
      hdr_pend_r <= 1'b0;
      type_r     <= '0;
      has_hdr_r  <= 1'b0;
      stamp_r    <= '0;
    end else begin
      zero_run_r <= zero_run_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      open_r     <= open_nxt;
      hdr_pend_r <= hdr_pend_nxt;
      type_r     <= type_nxt;
      has_hdr_r  <= has_hdr_nxt;
      if (accept) begin
        stamp_r <= stamp_nxt;
      end
    end
  end

  nus_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .din0      (din0),
    .din1      (d2),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign out_unit_offset = dout.offset;
  assign out_unit_length = dout.length;
  assign out_unit_type   = dout.ntype;
  assign out_frame_class = dout.fclass;
  assign out_unit_stamp  = dout.stamp;
  assign out_last_of_run = dout.last;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_buffer_end) |=> (pos_r == '0 && !open_r && !hdr_pend_r))
    else $error("buffer end did not clear the parser state");

  a_hdr_needs_unit: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pend_r |-> open_r)
    else $error("header byte pending without an open unit");

  a_type_needs_unit: assert property (@(posedge clk) disable iff (!rst_n)
    has_hdr_r |-> open_r)
    else $error("unit type held without an open unit");
`endif

endmodule

// ===== tb/tb_h264_nal_unit_splitter.sv =====
`timescale 1ns / 100ps

module tb_h264_nal_unit_splitter;
  import nus_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BYTES = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                in_data_byte;
  logic                      in_buffer_end;
  logic signed [STAMP_W-1:0] in_buffer_stamp;
  logic                      out_valid;
  logic                      out_ready;
  logic [OFF_W-1:0]          out_unit_offset;
  logic [LEN_W-1:0]          out_unit_length;
  logic [TYPE_W-1:0]         out_unit_type;
  logic [1:0]                out_frame_class;
  logic signed [STAMP_W-1:0] out_unit_stamp;
  logic                      out_last_of_run;

  h264_nal_unit_splitter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_buffer_end   (in_buffer_end),
    .in_buffer_stamp (in_buffer_stamp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_unit_offset (out_unit_offset),
    .out_unit_length (out_unit_length),
    .out_unit_type   (out_unit_type),
    .out_frame_class (out_frame_class),
    .out_unit_stamp  (out_unit_stamp),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the parser state.
  logic [1:0]                zero_count;
  logic [OFF_W-1:0]          byte_pos;
  logic [OFF_W-1:0]          unit_start;
  bit                        unit_open;
  bit                        header_due;
  bit                        header_seen;
  logic [TYPE_W-1:0]         unit_kind;
  logic signed [STAMP_W-1:0] buffer_stamp_q;

  desc_t      expected_units[$];
  logic [7:0] buf_bytes[$];
  int         errors;
  int         units_seen;
  int         bytes_sent;
  int         burst_left;
  int         cycle_count;
  bit         steady;
  bit         hold_req;

  initial begin
    zero_count     = '0;
    byte_pos       = '0;
    unit_start     = '0;
    unit_open      = 1'b0;
    header_due     = 1'b0;
    header_seen    = 1'b0;
    unit_kind      = '0;
    buffer_stamp_q = '0;
    errors         = 0;
    units_seen     = 0;
    bytes_sent     = 0;
    burst_left     = 0;
    steady         = 1'b0;
    hold_req       = 1'b0;
  end

  function automatic void append_byte(input logic [7:0] b);
    buf_bytes.insert(buf_bytes.size(), b);
  endfunction

  function automatic desc_t close_unit(input logic [OFF_W-1:0] from,
                                       input logic [OFF_W-1:0] upto);
    desc_t            u;
    logic [OFF_W-1:0] diff;
    diff     = upto - from;
    u.offset = from;
    u.length = (diff == '0) ? (LEN_W'(1) << OFF_W) : {1'b0, diff};
    u.ntype  = header_seen ? (unit_kind & TYPE_MASK) : '0;
    case (u.ntype)
      NAL_SPS, NAL_PPS: u.fclass = CLASS_PARAM;
      NAL_IDR:          u.fclass = CLASS_INTRA;
      NAL_SLICE:        u.fclass = CLASS_PRED;
      default:          u.fclass = CLASS_OTHER;
    endcase
    u.stamp = buffer_stamp_q;
    u.last  = 1'b0;
    return u;
  endfunction

  function automatic void predict_units(input logic [7:0] b, input bit at_end,
                                        input logic [STAMP_W-1:0] stamp);
    desc_t            found[2];
    int               n;
    logic [OFF_W-1:0] pos;
    logic [OFF_W-1:0] code_start;
    n   = 0;
    pos = byte_pos;
    if (pos == '0) begin
      buffer_stamp_q = stamp;
    end
    if (header_due) begin
      unit_kind   = b[TYPE_W-1:0] & TYPE_MASK;
      header_seen = 1'b1;
      header_due  = 1'b0;
    end
    if (b == BYTE_ONE && zero_count >= 2'd2) begin
      code_start = pos - ((zero_count == 2'd3) ? OFF_W'(3) : OFF_W'(2));
      if (unit_open) begin
        found[n] = close_unit(unit_start, code_start);
        n++;
      end
      unit_start  = code_start;
      unit_open   = 1'b1;
      header_due  = 1'b1;
      header_seen = 1'b0;
      unit_kind   = '0;
      zero_count  = '0;
    end else if (b == BYTE_ZERO) begin
      if (zero_count != 2'd3) begin
        zero_count++;
      end
    end else begin
      zero_count = '0;
    end
    if (at_end) begin
      if (unit_open) begin
        found[n] = close_unit(unit_start, pos + OFF_W'(1));
        n++;
      end
      unit_open   = 1'b0;
      header_due  = 1'b0;
      header_seen = 1'b0;
      unit_kind   = '0;
      zero_count  = '0;
      byte_pos    = '0;
    end else begin
      byte_pos = pos + OFF_W'(1);
    end
    if (n > 0) begin
      found[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_units.insert(expected_units.size(), found[i]);
    end
  endfunction

  function automatic logic [63:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("descriptor %0d %s: got %0h, expected %0h",
                                units_seen, field, got, want));
    end
  endtask

  // The sender offers in bursts, or without gaps in steady mode; a beat is taken
  // at the edge after a falling edge that saw in_ready high.
  task automatic send_byte(input logic [7:0] b, input bit at_end,
                           input logic [STAMP_W-1:0] stamp);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_buffer_end   <= at_end;
    in_buffer_stamp <= stamp;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_units(b, at_end, stamp);
    if (burst_left > 0) begin
      burst_left--;
    end
    bytes_sent++;
  endtask

  task automatic send_buffer(input logic [STAMP_W-1:0] stamp, input bit stray_stamps);
    logic [STAMP_W-1:0] s;
    for (int i = 0; i < buf_bytes.size(); i++) begin
      s = (i == 0 || !stray_stamps || $urandom_range(0, 3) != 0) ? stamp : rand_stamp();
      send_byte(buf_bytes[i], i == buf_bytes.size() - 1, s);
    end
  endtask

  task automatic build_random_buffer();
    int             units;
    int             zeros;
    int             plen;
    logic [TYPE_W-1:0] t;
    buf_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      plen = $urandom_range(1, 40);
      repeat (plen) begin
        case ($urandom_range(0, 3))
          0, 1:    append_byte(BYTE_ZERO);
          2:       append_byte(BYTE_ONE);
          default: append_byte(8'($urandom));
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
      units = $urandom_range(1, 5);
      for (int u = 0; u < units; u++) begin
        zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
        repeat (zeros) append_byte(BYTE_ZERO);
        append_byte(BYTE_ONE);
        if (u == units - 1 && $urandom_range(0, 7) == 0) begin
          break;
        end
        case ($urandom_range(0, 5))
          0:       t = NAL_SLICE;
          1:       t = NAL_IDR;
          2:       t = NAL_SPS;
          3:       t = NAL_PPS;
          default: t = TYPE_W'($urandom);
        endcase
        append_byte({3'($urandom), t});
        plen = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 600) : $urandom_range(0, 24);
        repeat (plen) begin
          append_byte(($urandom_range(0, 5) == 0) ? BYTE_ZERO : 8'($urandom));
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    // Leading junk, both code lengths, a code on the last byte.
    buf_bytes = '{8'h12, 8'h00, 8'h00, 8'h01, 8'hE7, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'h41, 8'h00, 8'h00, 8'h01};
    send_buffer(64'h8000_0000_0000_0000, 1'b0);
    // Zero header bytes opening the next code, once as its extra zero.
    buf_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'hFF};
    send_buffer(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    buf_bytes = '{8'h00};
    send_buffer(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
  endtask

  task automatic test_random_streams();
    int stop_at;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      build_random_buffer();
      send_buffer(rand_stamp(), 1'b1);
    end
  endtask

  task automatic test_back_pressure();
    steady   = 1'b1;
    hold_req = 1'b1;
    buf_bytes.delete();
    repeat (48) begin
      append_byte(BYTE_ZERO);
      append_byte(BYTE_ZERO);
      append_byte(BYTE_ONE);
      append_byte({3'($urandom), NAL_IDR});
    end
    send_buffer(rand_stamp(), 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_steady_stream();
    int stop_at;
    steady  = 1'b1;
    stop_at = bytes_sent + 200;
    while (bytes_sent < stop_at) begin
      build_random_buffer();
      send_buffer(rand_stamp(), 1'b0);
    end
    steady = 1'b0;
  endtask

  // Receiver: picks a new stall pattern whenever its mode count runs out, is always
  // ready in steady mode, and holds off entirely for a long stretch when asked to.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= mode_left[2];
        endcase
      end
    end
  end

  // Each result beat is compared at the falling edge before the edge that takes it.
  initial begin
    desc_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("descriptor %0d arrived with no unit pending",
                                    units_seen));
        end else begin
          want = expected_units.pop_front();
          check_field("unit_offset", 64'(out_unit_offset), 64'(want.offset));
          check_field("unit_length", 64'(out_unit_length), 64'(want.length));
          check_field("unit_type", 64'(out_unit_type), 64'(want.ntype));
          check_field("frame_class", 64'(out_frame_class), 64'(want.fclass));
          check_field("unit_stamp", out_unit_stamp, want.stamp);
          check_field("last_of_run", 64'(out_last_of_run), 64'(want.last));
        end
        units_seen++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_buffer_end   = 1'b0;
    in_buffer_stamp = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_streams();
    test_back_pressure();
    test_steady_stream();
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== h264_nal_unit_splitter.f =====
design/nus_pkg.sv
design/nus_fifo.sv
design/h264_nal_unit_splitter.sv
tb/tb_h264_nal_unit_splitter.sv
